### rtl/core/gfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_pkg: shared types and constants of the grouped free block allocator
// Sizes of the free list, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gfba_pkg;

    // Geometry of the free list
    localparam int GROUP_SIZE = 32;
    localparam int MAX_GROUPS = 64;
    localparam int BLOCK_W    = 16;

    // One group slot for the live top stack plus one per spilled group
    localparam int MEM_DEPTH  = (MAX_GROUPS + 1) * GROUP_SIZE;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int TC_W       = $clog2(GROUP_SIZE + 1);
    localparam int GD_W       = $clog2(MAX_GROUPS + 1);

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic push;        // free into a top stack with room
        logic spill;       // free into a full top stack: open a new group
        logic refuse;      // free refused, spill store full
        logic empty;       // allocate on an empty top stack
        logic pop_rd;      // allocate: step the count down, read the entry
        logic pop_zero;    // popped entry is block zero
        logic pop_refill;  // popped the last entry, reload a spilled group
        logic pop_plain;   // ordinary pop
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic tc_zero;
        logic tc_full;
        logic gd_zero;
        logic gd_full;
        logic rd_zero;
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/core/gfba_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_dp: allocator datapath
// Holds the free-number memory, the top stack count, the group depth and
// the result registers. The top stack lives in the memory slot selected by
// the group depth, so a spill or a reload only moves the group pointer.
// ----------------------------------------------------------------------------
module gfba_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  gfba_pkg::t_dp_cmd            i_cmd,
    input  wire [gfba_pkg::BLOCK_W-1:0]  i_block_number,
    output gfba_pkg::t_dp_sts            o_sts,
    output logic                         o_valid,
    output logic [gfba_pkg::BLOCK_W-1:0] o_granted_block,
    output logic                         o_no_space,
    output logic                         o_store_full,
    output logic [gfba_pkg::TC_W-1:0]    o_top_level
);
    import gfba_pkg::*;

    logic [BLOCK_W-1:0] mem [MEM_DEPTH];

    logic [TC_W-1:0]    r_tc, n_tc;
    logic [GD_W-1:0]    r_gd, n_gd;
    logic               r_valid, n_valid;
    logic [BLOCK_W-1:0] r_rdata;
    logic [BLOCK_W-1:0] r_granted, n_granted;
    logic               r_no_space, n_no_space;
    logic               r_store_full, n_store_full;

    logic [TC_W-1:0]    tc_m1;
    logic [GD_W-1:0]    gd_p1;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  spill_addr;
    logic [ADDR_W-1:0]  push_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    // Addresses: slot of the current top stack and of the next group
    assign tc_m1      = r_tc - 1'b1;
    assign gd_p1      = r_gd + 1'b1;
    assign base_addr  = ADDR_W'(r_gd) * ADDR_W'(GROUP_SIZE);
    assign spill_addr = ADDR_W'(gd_p1) * ADDR_W'(GROUP_SIZE);
    assign push_addr  = base_addr + ADDR_W'(r_tc);
    assign rd_addr    = base_addr + ADDR_W'(tc_m1);
    assign wr_en      = i_cmd.push | i_cmd.spill;
    assign wr_addr    = i_cmd.spill ? spill_addr : push_addr;

    // Status toward the controller
    assign o_sts.tc_zero = (r_tc == '0);
    assign o_sts.tc_full = (r_tc >= TC_W'(GROUP_SIZE));
    assign o_sts.gd_zero = (r_gd == '0);
    assign o_sts.gd_full = (r_gd >= GD_W'(MAX_GROUPS));
    assign o_sts.rd_zero = (r_rdata == '0);

    // Next counters and result
    always_comb begin
        n_tc         = r_tc;
        n_gd         = r_gd;
        n_valid      = 1'b0;
        n_granted    = r_granted;
        n_no_space   = r_no_space;
        n_store_full = r_store_full;
        if (i_cmd.push) begin
            n_tc         = r_tc + 1'b1;
            n_valid      = 1'b1;
            n_granted    = '0;
            n_no_space   = 1'b0;
            n_store_full = 1'b0;
        end
        if (i_cmd.spill) begin
            n_gd         = gd_p1;
            n_tc         = TC_W'(1);
            n_valid      = 1'b1;
            n_granted    = '0;
            n_no_space   = 1'b0;
            n_store_full = 1'b0;
        end
        if (i_cmd.refuse) begin
            n_valid      = 1'b1;
            n_granted    = '0;
            n_no_space   = 1'b0;
            n_store_full = 1'b1;
        end
        if (i_cmd.empty || i_cmd.pop_zero) begin
            n_tc         = '0;
            n_valid      = 1'b1;
            n_granted    = '0;
            n_no_space   = 1'b1;
            n_store_full = 1'b0;
        end
        if (i_cmd.pop_rd) begin
            n_tc = tc_m1;
        end
        if (i_cmd.pop_refill || i_cmd.pop_plain) begin
            n_valid      = 1'b1;
            n_granted    = r_rdata;
            n_no_space   = 1'b0;
            n_store_full = 1'b0;
        end
        if (i_cmd.pop_refill) begin
            n_gd = r_gd - 1'b1;
            n_tc = TC_W'(GROUP_SIZE);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc    <= '0;
            r_gd    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tc    <= n_tc;
            r_gd    <= n_gd;
            r_valid <= n_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_granted    <= n_granted;
        r_no_space   <= n_no_space;
        r_store_full <= n_store_full;
    end

    // Free-number memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_block_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_valid         = r_valid;
    assign o_granted_block = r_granted;
    assign o_no_space      = r_no_space;
    assign o_store_full    = r_store_full;
    assign o_top_level     = r_tc;

endmodule
`default_nettype wire

### rtl/core/gfba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfba_ctrl: allocator controller
// Accepts a request, decides the kind of transfer from datapath status and
// sequences the memory read of an allocate.
// ----------------------------------------------------------------------------
module gfba_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire                i_mode,
    input  gfba_pkg::t_dp_sts  i_sts,
    output logic               o_busy,
    output gfba_pkg::t_dp_cmd  o_cmd
);
    import gfba_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        if (!i_sts.tc_full) begin
                            o_cmd.push = 1'b1;
                        end else if (i_sts.gd_full) begin
                            o_cmd.refuse = 1'b1;
                        end else begin
                            o_cmd.spill = 1'b1;
                        end
                    end else if (i_sts.tc_zero) begin
                        o_cmd.empty = 1'b1;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end
                end
            end
            S_POP: begin
                o_busy = 1'b1;
                if (i_sts.rd_zero) begin
                    o_cmd.pop_zero = 1'b1;
                end else if (i_sts.tc_zero && !i_sts.gd_zero) begin
                    o_cmd.pop_refill = 1'b1;
                end else begin
                    o_cmd.pop_plain = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/grouped_free_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_unit: grouped free block list allocator
// Hands out and takes back block numbers from a top stack of free numbers
// backed by a store of spilled full groups.
//
// Usage:
//   A request is transferred on a rising edge with start high and busy low:
//   i_mode 0 allocates, i_mode 1 frees i_block_number.
//   Each request gives one result, shown for exactly one cycle with o_valid
//   high: o_granted_block, o_no_space, o_store_full, o_top_level.
//   A free answers in the cycle after its transfer and a new request may be
//   taken in that same cycle, so frees run at one per cycle. An allocate on
//   an empty top stack answers the same way, without busy.
//   Any other allocate holds busy for one cycle and answers after the
//   registered read of the free-number memory and the S_POP state, so the
//   next request is not taken before it answers. Spills and group reloads
//   move only the group pointer and need no extra state.
//   Reset empties the top stack and the spill store; no clearing pass runs.
//   The receiver cannot stall: every result is taken when shown.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_mode,
    input  wire [gfba_pkg::BLOCK_W-1:0]  i_block_number,
    output logic                         o_valid,
    output logic [gfba_pkg::BLOCK_W-1:0] o_granted_block,
    output logic                         o_no_space,
    output logic                         o_store_full,
    output logic [gfba_pkg::TC_W-1:0]    o_top_level
);
    import gfba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller
    gfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Datapath
    gfba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_block_number  (i_block_number),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_granted_block (o_granted_block),
        .o_no_space      (o_no_space),
        .o_store_full    (o_store_full),
        .o_top_level     (o_top_level)
    );

    // Checks
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_top_level <= TC_W'(GROUP_SIZE))
        else $error("top stack count beyond group size");

    a_free_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode |=> o_valid && !o_no_space && o_granted_block == '0)
        else $error("free transfer without a result in the next cycle");

    a_alloc_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_mode && !sts.tc_zero |=> !o_valid ##1 o_valid)
        else $error("allocate result not two cycles after transfer");

    a_no_space_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_space |-> o_top_level == '0 && !o_store_full)
        else $error("no-space result with entries left in the top stack");

endmodule
`default_nettype wire

### dv/grouped_free_block_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_unit_test: self-checking bench for the allocator
// Drives allocate and free requests over the start/busy handshake and tracks
// the free list in a scoreboard: the top stack and the spilled groups, so each
// result is predicted at transfer time and checked when its strobe shows.
// Covers empty and zero-block allocates, spills and refills.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_unit_test;
    import gfba_pkg::*;

    localparam bit MODE_ALLOC     = 1'b0;
    localparam bit MODE_FREE      = 1'b1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ZERO_PCT       = 3;

    typedef struct packed {
        logic [BLOCK_W-1:0] granted;
        logic               no_space;
        logic               store_full;
        logic [TC_W-1:0]    level;
    } answer_t;

    // Scoreboard: mirrors the free list and queues the expected answers
    class free_list_tracker;
        bit [BLOCK_W-1:0] top_stack [GROUP_SIZE];
        bit [BLOCK_W-1:0] group_store [MAX_GROUPS * GROUP_SIZE];
        int unsigned      top_count;
        int unsigned      group_depth;
        answer_t          pending_answers [$];
        int               errors;

        function void note_request(bit mode, bit [BLOCK_W-1:0] blk);
            answer_t          a;
            bit [BLOCK_W-1:0] got;
            a = '0;
            if (mode == MODE_ALLOC) begin
                if (top_count == 0) begin
                    a.no_space = 1'b1;
                end else begin
                    top_count--;
                    got = top_stack[top_count];
                    if (got == 0) begin
                        // block zero is never valid: drop the whole stack
                        top_count  = 0;
                        a.no_space = 1'b1;
                    end else begin
                        // last entry gone: reload the newest spilled group
                        if (top_count == 0 && group_depth > 0) begin
                            group_depth--;
                            for (int i = 0; i < GROUP_SIZE; i++)
                                top_stack[i] = group_store[group_depth * GROUP_SIZE + i];
                            top_count = GROUP_SIZE;
                        end
                        a.granted = got;
                    end
                end
            end else begin
                if (top_count == GROUP_SIZE && group_depth == MAX_GROUPS) begin
                    a.store_full = 1'b1;
                end else begin
                    // full top stack: spill it as one group
                    if (top_count == GROUP_SIZE) begin
                        for (int i = 0; i < GROUP_SIZE; i++)
                            group_store[group_depth * GROUP_SIZE + i] = top_stack[i];
                        group_depth++;
                        top_count = 0;
                    end
                    top_stack[top_count] = blk;
                    top_count++;
                end
            end
            a.level = TC_W'(top_count);
            pending_answers.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $error("result with no request outstanding: granted_block %0h", got.granted);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.granted !== want.granted) begin
                $error("granted_block: expected %0h, got %0h", want.granted, got.granted);
                errors++;
            end
            if (got.no_space !== want.no_space) begin
                $error("no_space: expected %0b, got %0b", want.no_space, got.no_space);
                errors++;
            end
            if (got.store_full !== want.store_full) begin
                $error("store_full: expected %0b, got %0b", want.store_full, got.store_full);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("top_level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = MODE_ALLOC;
    logic [BLOCK_W-1:0] i_block_number = '0;
    logic               o_valid;
    logic [BLOCK_W-1:0] o_granted_block;
    logic               o_no_space;
    logic               o_store_full;
    logic [TC_W-1:0]    o_top_level;

    free_list_tracker   tracker = new();
    int                 quiet_cycles = 0;

    grouped_free_block_allocator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .o_valid        (o_valid),
        .o_granted_block(o_granted_block),
        .o_no_space     (o_no_space),
        .o_store_full   (o_store_full),
        .o_top_level    (o_top_level)
    );

    always #10 i_clk = ~i_clk;

    // Result check and watchdog on quiet cycles
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (i_rst_n && o_valid === 1'b1)
            tracker.check_answer({o_granted_block, o_no_space, o_store_full, o_top_level});
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One request: optional idle cycles, then hold start until the transfer
    task automatic send_request(bit mode, bit [BLOCK_W-1:0] blk, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_mode         <= mode;
        i_block_number <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(mode, blk);
    endtask

    function automatic bit [BLOCK_W-1:0] pick_block();
        if ($urandom_range(99) < ZERO_PCT)
            return '0;
        return BLOCK_W'($urandom_range((1 << BLOCK_W) - 1));
    endfunction

    initial begin
        int idle_pcts [4] = '{0, 64, 19, 0};
        int free_pcts [4] = '{55, 50, 60, 45};
        int run_len;
        bit run_mode;
        int sent;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty allocate, bit extremes, zero block, plain pops
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_FREE, 16'hFFFF, 0);
        send_request(MODE_FREE, 16'h0000, 0);
        send_request(MODE_FREE, 16'h0001, 0);
        send_request(MODE_FREE, 16'h8000, 0);
        send_request(MODE_ALLOC, 16'hFFFF, 0);
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_FREE, 16'hAAAA, 0);
        send_request(MODE_FREE, 16'h5555, 0);
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_ALLOC, '0, 0);
        send_request(MODE_ALLOC, '0, 0);

        // Random runs of frees and allocates so groups spill and reload
        for (int p = 0; p < 4; p++) begin
            sent = 0;
            while (sent < 300) begin
                run_mode = ($urandom_range(99) < free_pcts[p]) ? MODE_FREE : MODE_ALLOC;
                run_len  = $urandom_range(1, 48);
                for (int k = 0; k < run_len; k++)
                    send_request(run_mode, pick_block(), idle_pcts[p]);
                sent += run_len;
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Let the last answers arrive
        while (tracker.pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
